// File: hdl/bpc_pkg.sv
`timescale 1ns / 1ps
// bpc_pkg: constants, types and register codes for the button press classifier
// and knob smoother; no dependencies, used by the interfaces and the top level

package bpc_pkg;

    // switch count, tracking stops at sixteen
    localparam int NUM_SWITCHES = 10;
    localparam int SW_LIMIT     = (NUM_SWITCHES > 16) ? 16 : NUM_SWITCHES;

    // fixed field widths
    localparam int TIME_W    = 32;
    localparam int FIELD_W   = 10;
    localparam int KNOB_W    = 10;
    localparam int CFG_IDX_W = 8;

    // knob smoother: floor((19*v + s) / 20) as a reciprocal multiply
    localparam int KNOB_SUM_W   = KNOB_W + 5;
    localparam int DIV20_SHIFT  = 20;
    localparam int DIV20_MUL_W  = 16;
    localparam int KNOB_PROD_W  = KNOB_SUM_W + DIV20_MUL_W;
    localparam logic [DIV20_MUL_W-1:0] DIV20_MUL = 16'd52429;

    typedef logic [SW_LIMIT-1:0] t_sw_mask;
    typedef logic [TIME_W-1:0]   t_time;
    typedef logic [FIELD_W-1:0]  t_field;
    typedef logic [KNOB_W-1:0]   t_knob;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESS_THR = 8'd0,
        CFG_LONG_THR  = 8'd1
    } t_cfg_reg;

    localparam t_time PRESS_THR_RESET = 32'd50000;
    localparam t_time LONG_THR_RESET  = 32'd1000000;

endpackage

// File: hdl/bpc_if.sv
`timescale 1ns / 1ps
// bpc_if: valid/ready channel interfaces for scan items, results and register writes
// depends on bpc_pkg for field widths

interface bpc_in_if;
    logic                 valid;
    logic                 ready;
    bpc_pkg::t_time       now_us;
    bpc_pkg::t_field      switch_levels;
    bpc_pkg::t_field      ignore_set;
    bpc_pkg::t_knob       knob_sample;

    modport source (output valid, output now_us, output switch_levels,
                    output ignore_set, output knob_sample, input ready);
    modport sink   (input valid, input now_us, input switch_levels,
                    input ignore_set, input knob_sample, output ready);
endinterface

interface bpc_out_if;
    logic                 valid;
    logic                 ready;
    bpc_pkg::t_field      pressed_mask;
    bpc_pkg::t_field      long_pressed_mask;
    bpc_pkg::t_field      held_mask;
    bpc_pkg::t_knob       knob_value;
    logic                 knob_changed;

    modport source (output valid, output pressed_mask, output long_pressed_mask,
                    output held_mask, output knob_value, output knob_changed,
                    input ready);
    modport sink   (input valid, input pressed_mask, input long_pressed_mask,
                    input held_mask, input knob_value, input knob_changed,
                    output ready);
endinterface

interface bpc_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [bpc_pkg::CFG_IDX_W-1:0]       index;
    bpc_pkg::t_time                      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/button_press_classifier_knob_smoother.sv
`timescale 1ns / 1ps
// button_press_classifier_knob_smoother: top level, switch press timing and knob filter
// depends on bpc_pkg and the channel interfaces in bpc_if.sv
//
//  channel  | dir | port   | payload
//  ---------+-----+--------+-----------------------------------------------------
//  scan     | in  | i_in   | now_us, switch_levels, ignore_set, knob_sample
//  result   | out | o_out  | pressed_mask, long_pressed_mask, held_mask,
//           |     |        | knob_value, knob_changed
//  config   | in  | i_cfg  | index (0 press threshold, 1 long threshold), data
//
// result registered after the input register and evaluate stage; one item per cycle
// unstalled, set by the single evaluate stage that reads and updates switch/knob state
// synchronous active-low reset clears state, thresholds return to defaults
// a stalled result holds in the output register; the input register still fills,
// and takes a new item in the same cycle the stalled result is transferred
// config writes are always taken, one per cycle

module button_press_classifier_knob_smoother (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bpc_in_if.sink        i_in,
    bpc_out_if.source     o_out,
    bpc_cfg_if.sink       i_cfg
);

    // thresholds
    bpc_pkg::t_time r_press_thr;
    bpc_pkg::t_time r_long_thr;

    // input register
    logic             r_s1_vld;
    bpc_pkg::t_time   r_now;
    bpc_pkg::t_field  r_levels;
    bpc_pkg::t_field  r_ign_set;
    bpc_pkg::t_knob   r_sample;

    // tracked state
    bpc_pkg::t_sw_mask r_held;
    bpc_pkg::t_sw_mask r_ignore;
    bpc_pkg::t_time    r_start [bpc_pkg::SW_LIMIT];
    bpc_pkg::t_knob    r_knob;

    // result register
    logic             r_out_vld;
    bpc_pkg::t_field  r_out_short;
    bpc_pkg::t_field  r_out_long;
    bpc_pkg::t_field  r_out_held;
    bpc_pkg::t_knob   r_out_knob;
    logic             r_out_chg;

    // evaluate-stage logic
    logic              adv;
    bpc_pkg::t_sw_mask down;
    bpc_pkg::t_sw_mask ign_all;
    bpc_pkg::t_sw_mask rise;
    bpc_pkg::t_sw_mask fall;
    bpc_pkg::t_sw_mask judge;
    bpc_pkg::t_sw_mask short_m;
    bpc_pkg::t_sw_mask long_m;
    bpc_pkg::t_sw_mask n_ignore;
    logic [bpc_pkg::SW_LIMIT+bpc_pkg::FIELD_W-1:0] levels_pad;
    logic [bpc_pkg::SW_LIMIT+bpc_pkg::FIELD_W-1:0] ign_pad;
    logic [bpc_pkg::SW_LIMIT+bpc_pkg::FIELD_W-1:0] short_pad;
    logic [bpc_pkg::SW_LIMIT+bpc_pkg::FIELD_W-1:0] long_pad;
    logic [bpc_pkg::SW_LIMIT+bpc_pkg::FIELD_W-1:0] held_pad;
    logic [bpc_pkg::KNOB_SUM_W-1:0]  knob_sum;
    logic [bpc_pkg::KNOB_PROD_W-1:0] knob_prod;
    bpc_pkg::t_knob    n_knob;

    // evaluate stage fires when the result register is free or being emptied
    assign adv         = r_s1_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready  = !r_s1_vld || adv;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid             = r_out_vld;
    assign o_out.pressed_mask      = r_out_short;
    assign o_out.long_pressed_mask = r_out_long;
    assign o_out.held_mask         = r_out_held;
    assign o_out.knob_value        = r_out_knob;
    assign o_out.knob_changed      = r_out_chg;

    // switches past the input width read level zero, i.e. held
    assign levels_pad = {{bpc_pkg::SW_LIMIT{1'b0}}, r_levels};
    assign ign_pad    = {{bpc_pkg::SW_LIMIT{1'b0}}, r_ign_set};
    assign down       = ~levels_pad[bpc_pkg::SW_LIMIT-1:0];
    assign ign_all    = r_ignore | ign_pad[bpc_pkg::SW_LIMIT-1:0];

    assign rise     = down & ~r_held;
    assign fall     = r_held & ~down;
    // a release with its ignore bit set is swallowed and clears the bit
    assign judge    = fall & ~ign_all;
    assign n_ignore = ign_all & ~fall;

    // per-switch duration compare, wrapping subtraction
    always_comb begin
        for (int i = 0; i < bpc_pkg::SW_LIMIT; i++) begin
            short_m[i] = judge[i] && ((r_now - r_start[i]) > r_press_thr);
            long_m[i]  = judge[i] && ((r_now - r_start[i]) > r_long_thr);
        end
    end

    assign short_pad = {{bpc_pkg::FIELD_W{1'b0}}, short_m};
    assign long_pad  = {{bpc_pkg::FIELD_W{1'b0}}, long_m};
    assign held_pad  = {{bpc_pkg::FIELD_W{1'b0}}, down};

    // 19*v as shift-add, then divide by 20 through the reciprocal
    assign knob_sum  = ({5'd0, r_knob} << 4) + ({5'd0, r_knob} << 1)
                     + {5'd0, r_knob} + {5'd0, r_sample};
    assign knob_prod = {{bpc_pkg::DIV20_MUL_W{1'b0}}, knob_sum}
                     * {{bpc_pkg::KNOB_SUM_W{1'b0}}, bpc_pkg::DIV20_MUL};
    assign n_knob    = knob_prod[bpc_pkg::DIV20_SHIFT +: bpc_pkg::KNOB_W];

    // threshold registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_thr <= bpc_pkg::PRESS_THR_RESET;
            r_long_thr  <= bpc_pkg::LONG_THR_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                bpc_pkg::CFG_PRESS_THR: r_press_thr <= i_cfg.data;
                bpc_pkg::CFG_LONG_THR:  r_long_thr  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_now     <= i_in.now_us;
            r_levels  <= i_in.switch_levels;
            r_ign_set <= i_in.ignore_set;
            r_sample  <= i_in.knob_sample;
        end
    end

    // tracked state, updated once per evaluated item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= '0;
            r_ignore <= '0;
            r_knob   <= '0;
            for (int i = 0; i < bpc_pkg::SW_LIMIT; i++) begin
                r_start[i] <= '0;
            end
        end else if (adv) begin
            r_held   <= down;
            r_ignore <= n_ignore;
            r_knob   <= n_knob;
            for (int i = 0; i < bpc_pkg::SW_LIMIT; i++) begin
                if (rise[i]) begin
                    r_start[i] <= r_now;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_short <= short_pad[bpc_pkg::FIELD_W-1:0];
            r_out_long  <= long_pad[bpc_pkg::FIELD_W-1:0];
            r_out_held  <= held_pad[bpc_pkg::FIELD_W-1:0];
            r_out_knob  <= n_knob;
            r_out_chg   <= (n_knob != r_knob);
        end
    end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for button_press_classifier_knob_smoother, scan items in,
// press/knob reports out, checked against an in-bench predictor of switch and knob state
// depends on bpc_pkg and the channel interfaces in hdl/bpc_if.sv

module tb;

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 7;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int SETTLE_CYCLES   = 4;      // input and result registers plus margin
    localparam int HOLD_OFF_CYCLES = 200;

    // one scan tick as offered on the input channel
    typedef struct packed {
        bpc_pkg::t_time  now_us;
        bpc_pkg::t_field levels;
        bpc_pkg::t_field ignore_set;
        bpc_pkg::t_knob  knob;
    } t_scan;

    // one report as seen on the result channel
    typedef struct packed {
        bpc_pkg::t_field pressed;
        bpc_pkg::t_field long_pressed;
        bpc_pkg::t_field held;
        bpc_pkg::t_knob  knob;
        logic            knob_changed;
    } t_press_report;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    bpc_in_if  scan_if();
    bpc_out_if report_if();
    bpc_cfg_if cfg_if();

    button_press_classifier_knob_smoother dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (scan_if),
        .o_out   (report_if),
        .i_cfg   (cfg_if)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // predictor state: thresholds, held/ignore masks, press start times, knob
    // ------------------------------------------------------------------
    bpc_pkg::t_time press_thr;
    bpc_pkg::t_time long_thr;
    logic [15:0]    held_sw;
    logic [15:0]    ignore_sw;
    bpc_pkg::t_time press_start [16];
    int unsigned    knob_smooth;

    // stimulus generator's own view of the switches, used to shape releases
    bpc_pkg::t_field gen_levels;
    bpc_pkg::t_time  gen_now;
    bpc_pkg::t_time  gen_start [bpc_pkg::FIELD_W];
    bpc_pkg::t_knob  knob_target;

    t_scan         pending_scans [$];
    t_press_report expected_reports [$];

    t_scan         offered;
    t_press_report want;
    int            send_gap;
    int            stall_left;
    bit            scan_busy;
    bit            accept;
    bit            quiet;        // no idling on either side from here on
    bit            hold_go;      // ask the receiver for one long hold-off
    bit            hold_done;
    int            mismatches;
    int            cycles;

    // classify one scan: release timing against both thresholds, then knob filter
    function automatic t_press_report classify_scan(t_scan s);
        t_press_report  r;
        logic [15:0]    now_held;
        logic [15:0]    short_m;
        logic [15:0]    long_m;
        bpc_pkg::t_time dur;
        int unsigned    nk;
        logic           down;
        now_held = '0;
        short_m  = '0;
        long_m   = '0;
        // the ignore mask lands before this scan's releases are looked at
        ignore_sw |= 16'(s.ignore_set);
        for (int i = 0; i < bpc_pkg::SW_LIMIT; i++) begin
            // switches past the input width read level zero, so they count as held
            down = (i < bpc_pkg::FIELD_W) ? ~s.levels[i] : 1'b1;
            if (down)
                now_held[i] = 1'b1;
            if (down && !held_sw[i])
                press_start[i] = s.now_us;
            if (!down && held_sw[i]) begin
                if (ignore_sw[i]) begin
                    // swallowed release clears the ignore bit
                    ignore_sw[i] = 1'b0;
                end else begin
                    dur = s.now_us - press_start[i];   // wraps modulo 2^32
                    if (dur > long_thr)
                        long_m[i] = 1'b1;
                    if (dur > press_thr)
                        short_m[i] = 1'b1;
                end
            end
        end
        held_sw = now_held;

        nk = (19 * knob_smooth + s.knob) / 20;
        r.knob_changed = (nk != knob_smooth);
        knob_smooth    = nk;

        r.pressed      = short_m[bpc_pkg::FIELD_W-1:0];
        r.long_pressed = long_m[bpc_pkg::FIELD_W-1:0];
        r.held         = now_held[bpc_pkg::FIELD_W-1:0];
        r.knob         = bpc_pkg::t_knob'(nk);
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
        if (exp_val !== got_val) begin
            $error("%s: expected %0h, got %0h", name, exp_val, got_val);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // scan driver: pops pending scans, random gap bursts between transfers
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            scan_if.valid <= 1'b0;
            send_gap = 0;
        end else begin
            scan_busy = scan_if.valid;
            if (scan_if.valid && scan_if.ready) begin
                // transfer done: predict its report now, config is stable here
                expected_reports.push_back(classify_scan(offered));
                scan_busy = 1'b0;
            end
            if (!scan_busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_scans.size() > 0) begin
                    offered = pending_scans.pop_front();
                    scan_if.now_us        <= offered.now_us;
                    scan_if.switch_levels <= offered.levels;
                    scan_if.ignore_set    <= offered.ignore_set;
                    scan_if.knob_sample   <= offered.knob;
                    scan_busy = 1'b1;
                    if (!quiet && $urandom_range(0, 9) == 0)
                        send_gap = $urandom_range(1, 16);
                end
            end
            // valid gets exactly one update per edge
            scan_if.valid <= scan_busy;
        end
    end

    // ------------------------------------------------------------------
    // report monitor: compares each transfer with the oldest prediction,
    // drives ready with random stall bursts and one long hold-off
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            report_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (report_if.valid && report_if.ready) begin
                if (expected_reports.size() == 0) begin
                    $error("report with no scan pending: held_mask %0h", report_if.held_mask);
                    mismatches++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("pressed_mask", want.pressed, report_if.pressed_mask);
                    check_field("long_pressed_mask", want.long_pressed,
                                report_if.long_pressed_mask);
                    check_field("held_mask", want.held, report_if.held_mask);
                    check_field("knob_value", want.knob, report_if.knob_value);
                    check_field("knob_changed", want.knob_changed, report_if.knob_changed);
                end
            end
            // long hold-off so the pipeline fills and back-pressures the scan side
            if (hold_go && !hold_done) begin
                stall_left = HOLD_OFF_CYCLES;
                hold_done  = 1'b1;
            end
            if (stall_left > 0) begin
                stall_left--;
                accept = 1'b0;
            end else begin
                accept = 1'b1;
                if (!quiet && $urandom_range(0, 9) == 0)
                    stall_left = $urandom_range(1, 16);
            end
            report_if.ready <= accept;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // queue one scan and keep the generator's switch view in step
    task automatic queue_scan(bpc_pkg::t_time now, bpc_pkg::t_field lv,
                              bpc_pkg::t_field ign, bpc_pkg::t_knob k);
        t_scan s;
        s = '{now, lv, ign, k};
        for (int i = 0; i < bpc_pkg::FIELD_W; i++)
            if (!lv[i] && gen_levels[i])
                gen_start[i] = now;
        gen_levels = lv;
        gen_now    = now;
        pending_scans.push_back(s);
    endtask

    // mostly well-formed press/hold/release traffic, some raw noise
    task automatic random_scan();
        bpc_pkg::t_field lv;
        bpc_pkg::t_field ign;
        bpc_pkg::t_knob  k;
        bpc_pkg::t_time  now;
        int              sw;
        lv = gen_levels;
        case ($urandom_range(0, 5))
            0:       now = gen_now;                          // zero elapsed time
            1:       now = gen_now + $urandom_range(1, 30);
            2:       now = gen_now + $urandom_range(0, 3000);
            3:       now = gen_now + $urandom_range(0, 200000);
            4:       now = gen_now + $urandom_range(0, 3000000);
            default: now = $urandom;                         // arbitrary jump, wraps
        endcase
        if ($urandom_range(0, 7) == 0) begin
            lv = bpc_pkg::t_field'($urandom);
        end else begin
            for (int i = 0; i < bpc_pkg::FIELD_W; i++)
                if ($urandom_range(0, 5) == 0)
                    lv[i] = ~lv[i];
            // release one held switch right at a threshold (one below, at, one above)
            if ($urandom_range(0, 4) == 0 && gen_levels != '1) begin
                do
                    sw = $urandom_range(0, bpc_pkg::FIELD_W - 1);
                while (gen_levels[sw]);
                now = gen_start[sw] + ($urandom_range(0, 1) ? press_thr : long_thr)
                      + $urandom_range(0, 2) - 1;
                lv[sw] = 1'b1;
            end
        end
        case ($urandom_range(0, 15))
            0:       ign = '1;
            1, 2:    ign = bpc_pkg::t_field'($urandom);
            default: ign = '0;
        endcase
        // knob mostly sits on a target so the filter settles and stops changing
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 2))
                0:       knob_target = '0;
                1:       knob_target = '1;
                default: knob_target = bpc_pkg::t_knob'($urandom);
            endcase
        end
        k = ($urandom_range(0, 4) == 0) ? bpc_pkg::t_knob'($urandom) : knob_target;
        queue_scan(now, lv, ign, k);
    endtask

    // sender pause: nothing left to send or expect, then pipeline latency
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (pending_scans.size() != 0 || scan_if.valid || expected_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(bpc_pkg::t_cfg_reg idx, bpc_pkg::t_time val);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do
            @(posedge i_clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            bpc_pkg::CFG_PRESS_THR: press_thr = val;
            bpc_pkg::CFG_LONG_THR:  long_thr  = val;
            default: ;
        endcase
    endtask

    task automatic run_phase(int n, bit with_hold, bit no_idle);
        @(negedge i_clk);
        quiet = no_idle;
        repeat (n) random_scan();
        if (with_hold)
            hold_go = 1'b1;
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        // every block input known from time zero
        scan_if.valid         = 1'b0;
        scan_if.now_us        = '0;
        scan_if.switch_levels = '1;
        scan_if.ignore_set    = '0;
        scan_if.knob_sample   = '0;
        report_if.ready       = 1'b0;
        cfg_if.valid          = 1'b0;
        cfg_if.index          = '0;
        cfg_if.data           = '0;

        // predictor matches the post-reset block
        press_thr   = bpc_pkg::PRESS_THR_RESET;
        long_thr    = bpc_pkg::LONG_THR_RESET;
        held_sw     = '0;
        ignore_sw   = '0;
        knob_smooth = 0;
        for (int i = 0; i < 16; i++)
            press_start[i] = '0;
        gen_levels  = '1;
        gen_now     = '0;
        knob_target = '0;
        for (int i = 0; i < bpc_pkg::FIELD_W; i++)
            gen_start[i] = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed scans at the reset thresholds (50000 / 1000000)
        @(negedge i_clk);
        queue_scan(32'd0,       10'h3FF, 10'h000, 10'd0);     // nothing held, knob at rest
        queue_scan(32'd100,     10'h000, 10'h000, 10'd1023);  // every switch pressed
        queue_scan(32'd50100,   10'h3FF, 10'h000, 10'd1023);  // duration equals threshold
        queue_scan(32'd60000,   10'h000, 10'h000, 10'd1023);
        queue_scan(32'd110001,  10'h3FF, 10'h000, 10'd1023);  // one over: short press
        queue_scan(32'd200000,  10'h3FE, 10'h000, 10'd0);
        queue_scan(32'd700000,  10'h3FE, 10'h000, 10'd0);     // held across scans
        queue_scan(32'd1200001, 10'h3FF, 10'h000, 10'd0);     // long and short press
        queue_scan(32'd1300000, 10'h3FD, 10'h002, 10'd0);     // press with ignore set
        queue_scan(32'd2400000, 10'h3FF, 10'h000, 10'd0);     // release swallowed
        queue_scan(32'd2500000, 10'h3FD, 10'h000, 10'd512);
        queue_scan(32'd3600000, 10'h3FF, 10'h000, 10'd512);   // ignore gone, flags again
        queue_scan(32'd3700000, 10'h3FF, 10'h200, 10'd512);   // ignore on a released switch
        queue_scan(32'd3800000, 10'h1FF, 10'h000, 10'd512);
        queue_scan(32'd3800000, 10'h3FF, 10'h000, 10'd512);   // swallowed, zero duration
        queue_scan(32'd3900000, 10'h1FF, 10'h000, 10'd512);
        queue_scan(32'd3900000, 10'h3FF, 10'h000, 10'd512);   // zero duration, no flag
        queue_scan(32'hFFFF_FFF0, 10'h000, 10'h000, 10'd0);
        queue_scan(32'd1000000, 10'h3FF, 10'h000, 10'd0);     // timestamp wrapped
        queue_scan(32'd5,       10'h2AA, 10'h3FF, 10'd1023);  // full ignore mask
        queue_scan(32'd10,      10'h155, 10'h000, 10'd1023);  // even released, odd pressed
        queue_scan(32'd20,      10'h3FF, 10'h000, 10'd1023);
        queue_scan(32'd9000000, 10'h000, 10'h000, 10'd0);
        wait_drained();

        // small thresholds: plenty of short and long presses
        write_reg(bpc_pkg::CFG_PRESS_THR, 32'd100);
        write_reg(bpc_pkg::CFG_LONG_THR, 32'd2000);
        run_phase(300, 1'b0, 1'b0);

        // extremes: any nonzero duration is a press, nothing is long
        write_reg(bpc_pkg::CFG_PRESS_THR, '0);
        write_reg(bpc_pkg::CFG_LONG_THR, '1);
        run_phase(150, 1'b0, 1'b0);

        // swapped extremes, with the receiver holding off
        write_reg(bpc_pkg::CFG_PRESS_THR, '1);
        write_reg(bpc_pkg::CFG_LONG_THR, '0);
        run_phase(150, 1'b1, 1'b0);

        // back to the power-on values
        write_reg(bpc_pkg::CFG_PRESS_THR, bpc_pkg::PRESS_THR_RESET);
        write_reg(bpc_pkg::CFG_LONG_THR, bpc_pkg::LONG_THR_RESET);
        run_phase(200, 1'b0, 1'b0);

        // random thresholds, full rate on both sides
        write_reg(bpc_pkg::CFG_PRESS_THR, $urandom_range(0, 100000));
        write_reg(bpc_pkg::CFG_LONG_THR, $urandom_range(100000, 3000000));
        run_phase(200, 1'b0, 1'b1);

        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/bpc_pkg.sv
hdl/bpc_if.sv
hdl/button_press_classifier_knob_smoother.sv
verif/tb.sv
